// File: design/ftcl_pkg.sv
// shared types and codes for the frame tick timer list
`default_nettype none
package ftcl_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_ADD       = 2'd1;
  localparam logic [1:0] CMD_CLR_NOW   = 2'd2;
  localparam logic [1:0] CMD_CLR_NEXT  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_WAIT   = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  // input request
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] wait_ticks;
    logic [7:0]         callback_tag;
  } in_t;

  // result item
  typedef struct packed {
    logic       fired;
    logic [7:0] fired_tag;
    logic [1:0] status;
    logic [4:0] active_count;
    logic       last;
  } out_t;

  // one timer held in a cell
  typedef struct packed {
    logic [7:0]         tag;
    logic signed [31:0] remaining;
  } entry_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: design/ftcl_cell.sv
// one list cell: loads a new timer or takes its right neighbor's timer
`default_nettype none
module ftcl_cell
  import ftcl_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    new_d,
  input  wire entry_t    nbr_d,
  output entry_t         q
);

  entry_t q_r;
  entry_t q_nxt;

  // load wins over the shift toward the head
  always_comb begin
    q_nxt = q_r;
    if (ctl.load) begin
      q_nxt = new_d;
    end else if (ctl.shift) begin
      q_nxt = nbr_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// File: design/ftcl_fire_buf.sv
// buffer of expired tags collected during a tick walk
`default_nettype none
module ftcl_fire_buf #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic [7:0]    wr_tag,
  input  wire logic [IW-1:0] rd_idx,
  output logic [7:0]         rd_tag
);

  logic [7:0] tag_r [SLOTS];

  // write one expired tag per walk step
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r[wr_idx] <= wr_tag;
    end
  end

  assign rd_tag = tag_r[rd_idx];

endmodule
`default_nettype wire

// File: design/frame_tick_callback_timer_list_top.sv
// top level of the frame tick timer list: control, cell chain, result register
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_ready, in_data    | in
//   result  | out_valid, out_ready, out_data | out
//
// add and clear requests give one result each, as does a tick that meets a deferred clear.
// a tick over n timers otherwise walks the chain, one timer leaving the head
// each cycle, then gives one result per expired timer (or one if none expired).
// rst_n empties the list and drops a deferred clear; the cells are not reset.
// a request is taken only when idle and the result register can be loaded.
`default_nettype none
module frame_tick_callback_timer_list_top
  import ftcl_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] active_r, active_nxt;
  logic          clr_req_r, clr_req_nxt;
  logic [CW-1:0] u_r, u_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] nf_r, nf_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  entry_t        cell_q [SLOTS];
  entry_t        new_d;
  entry_t        head;
  logic signed [31:0] dec;
  logic          survive;
  logic          can_load;
  logic          accept;
  logic          add_wr;
  logic          walk_step;
  logic [CW-1:0] ins_idx;
  logic [7:0]    fire_tag;
  logic          wait_bad;

  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && can_load;
  assign accept    = in_valid && in_ready;
  assign head      = cell_q[0];
  assign dec       = head.remaining - 32'sd1;
  assign survive   = (dec > 32'sd0);
  assign walk_step = (state_r == S_WALK);
  assign ins_idx   = u_r + w_r - CW'(1);
  assign wait_bad  = (in_data.wait_ticks == 32'sd0) || in_data.wait_ticks[31];
  assign add_wr    = accept && (in_data.cmd == CMD_ADD) && !wait_bad
                     && (count_r != CW'(SLOTS));

  // data for a loading cell: a new timer on add, the decremented head on a walk
  always_comb begin
    if (walk_step) begin
      new_d.tag       = head.tag;
      new_d.remaining = dec;
    end else begin
      new_d.tag       = in_data.callback_tag;
      new_d.remaining = in_data.wait_ticks;
    end
  end

  // cell chain, head at index 0
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;
    assign ctl.load  = (add_wr && (count_r == CW'(i)))
                       || (walk_step && survive && (ins_idx == CW'(i)));
    assign ctl.shift = walk_step;
    if (i == SLOTS - 1) begin : g_end
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i + 1];
    end
    ftcl_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .new_d (new_d),
      .nbr_d (nbr),
      .q     (cell_q[i])
    );
  end

  // expired tags in list order
  ftcl_fire_buf #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_fire_buf (
    .clk    (clk),
    .wr_en  (walk_step && !survive),
    .wr_idx (nf_r[IW-1:0]),
    .wr_tag (head.tag),
    .rd_idx (rd_r),
    .rd_tag (fire_tag)
  );

  // control and result register next values
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    clr_req_nxt   = clr_req_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    nf_nxt        = nf_r;
    rd_nxt        = rd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.fired        = 1'b0;
          out_nxt.fired_tag    = 8'd0;
          out_nxt.status       = ST_OK;
          out_nxt.active_count = 5'(active_r);
          out_nxt.last         = 1'b1;
          out_valid_nxt        = 1'b1;
          unique case (in_data.cmd)
            CMD_TICK: begin
              if (clr_req_r || (count_r == '0)) begin
                clr_req_nxt          = 1'b0;
                count_nxt            = '0;
                active_nxt           = '0;
                out_nxt.active_count = 5'd0;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_WALK;
                u_nxt         = count_r;
                w_nxt         = '0;
                nf_nxt        = '0;
              end
            end
            CMD_ADD: begin
              if (wait_bad) begin
                out_nxt.status = ST_BAD_WAIT;
              end else if (count_r == CW'(SLOTS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_CLR_NOW: begin
              count_nxt            = '0;
              active_nxt           = '0;
              out_nxt.active_count = 5'd0;
            end
            CMD_CLR_NEXT: begin
              clr_req_nxt = 1'b1;
            end
            default: begin
              out_nxt.status = ST_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        u_nxt = u_r - CW'(1);
        if (survive) begin
          w_nxt = w_r + CW'(1);
        end else begin
          nf_nxt = nf_r + CW'(1);
        end
        if (u_r == CW'(1)) begin
          count_nxt  = w_nxt;
          active_nxt = w_nxt;
          rd_nxt     = '0;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_OK;
          out_nxt.active_count = 5'(active_r);
          if (nf_r == '0) begin
            out_nxt.fired     = 1'b0;
            out_nxt.fired_tag = 8'd0;
            out_nxt.last      = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            out_nxt.fired     = 1'b1;
            out_nxt.fired_tag = fire_tag;
            out_nxt.last      = ((CW'(rd_r) + CW'(1)) == nf_r);
            rd_nxt            = rd_r + IW'(1);
            if ((CW'(rd_r) + CW'(1)) == nf_r) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      clr_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      clr_req_r   <= clr_req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk counters and result payload
  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    w_r   <= w_nxt;
    nf_r  <= nf_nxt;
    rd_r  <= rd_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: sim/tb_frame_tick_callback_timer_list_top.sv
// testbench for the frame tick timer list: random and directed requests against a predictor
`default_nettype none
module tb_frame_tick_callback_timer_list_top;
  import ftcl_pkg::*;

  localparam int SLOTS = 16;

  // one queued request, optionally held back until the block has drained
  typedef struct {
    in_t req;
    bit  drain_first;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pending_req_t req_q[$];
  out_t         timer_results_q[$];

  // predicted timer list
  logic [7:0]         tl_tag[SLOTS];
  logic signed [31:0] tl_left[SLOTS];
  logic               tl_pend[SLOTS];
  int                 tl_count = 0;
  logic               clr_waiting = 1'b0;

  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_ticks = 0;
  int n_adds = 0;
  int n_rejects = 0;
  int n_fired = 0;
  int max_burst = 0;

  wire no_idle = (n_taken >= 120) && (n_taken < 180);

  frame_tick_callback_timer_list_top #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    n_errors++;
    $display("mismatch: %s", msg);
  endtask

  // advance the predicted list by one request and queue the results it causes
  function automatic void step_timer_list(input in_t req);
    out_t               res;
    logic [7:0]         fired_tags[$];
    logic signed [31:0] left;
    int                 w;
    int                 act;
    res = '0;
    case (req.cmd)
      CMD_ADD: begin
        n_adds++;
        if ($signed(req.wait_ticks) <= 0) begin
          res.status = ST_BAD_WAIT;
          n_rejects++;
        end else if (tl_count >= SLOTS) begin
          res.status = ST_FULL;
          n_rejects++;
        end else begin
          tl_tag[tl_count]  = req.callback_tag;
          tl_left[tl_count] = req.wait_ticks;
          tl_pend[tl_count] = 1'b1;
          tl_count++;
        end
      end
      CMD_CLR_NOW: begin
        tl_count = 0;
      end
      CMD_CLR_NEXT: begin
        clr_waiting = 1'b1;
      end
      default: begin
        n_ticks++;
        if (clr_waiting) begin
          // deferred clear takes the place of the tick
          clr_waiting = 1'b0;
          tl_count = 0;
        end else begin
          w = 0;
          for (int i = 0; i < tl_count; i++) begin
            left = tl_left[i] - 1;
            if (left <= 0) begin
              fired_tags = {fired_tags, tl_tag[i]};
            end else begin
              tl_tag[w]  = tl_tag[i];
              tl_left[w] = left;
              tl_pend[w] = 1'b0;
              w++;
            end
          end
          tl_count = w;
        end
      end
    endcase
    act = 0;
    for (int i = 0; i < tl_count; i++) begin
      if (!tl_pend[i]) act++;
    end
    res.active_count = 5'(act);
    if (fired_tags.size() == 0) begin
      res.last = 1'b1;
      timer_results_q = {timer_results_q, res};
    end else begin
      n_fired += fired_tags.size();
      if (fired_tags.size() > max_burst) max_burst = fired_tags.size();
      foreach (fired_tags[k]) begin
        res.fired     = 1'b1;
        res.fired_tag = fired_tags[k];
        res.status    = ST_OK;
        res.last      = (k == fired_tags.size() - 1);
        timer_results_q = {timer_results_q, res};
      end
    end
  endfunction

  function automatic void queue_req(input logic [1:0] cmd, input logic [31:0] wait_val,
                                    input logic [7:0] tag, input bit drain_first);
    pending_req_t p;
    p.req.cmd          = cmd;
    p.req.wait_ticks   = wait_val;
    p.req.callback_tag = tag;
    p.drain_first      = drain_first;
    req_q = {req_q, p};
  endfunction

  // request driver: holds each request until taken, idles at random
  always @(posedge clk) begin
    logic hold;
    logic gap;
    hold = in_valid && !in_ready;
    gap  = !no_idle && ($urandom_range(0, 99) < 32);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_timer_list(in_data);
        n_taken++;
      end
      if (hold) begin
        in_valid <= 1'b1;
      end else if (req_q.size() != 0 && !gap &&
                   !(req_q[0].drain_first && timer_results_q.size() != 0)) begin
        in_data  <= req_q[0].req;
        in_valid <= 1'b1;
        void'(req_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compares each taken result with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (timer_results_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing predicted", n_results));
      end else begin
        want = timer_results_q.pop_front();
        if (out_data.fired !== want.fired)
          report_error($sformatf("result %0d fired %b, predicted %b",
                                 n_results, out_data.fired, want.fired));
        if (out_data.fired_tag !== want.fired_tag)
          report_error($sformatf("result %0d fired_tag %0d, predicted %0d",
                                 n_results, out_data.fired_tag, want.fired_tag));
        if (out_data.status !== want.status)
          report_error($sformatf("result %0d status %0d, predicted %0d",
                                 n_results, out_data.status, want.status));
        if (out_data.active_count !== want.active_count)
          report_error($sformatf("result %0d active_count %0d, predicted %0d",
                                 n_results, out_data.active_count, want.active_count));
        if (out_data.last !== want.last)
          report_error($sformatf("result %0d last %b, predicted %b",
                                 n_results, out_data.last, want.last));
      end
      n_results++;
    end
    out_ready <= rst_n && (no_idle || ($urandom_range(0, 99) >= 32));
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    int n_rand;
    logic [31:0] w;
    logic [1:0]  c;
    bit          paused;

    // bad waits on an empty list
    queue_req(CMD_ADD, 32'h0000_0000, 8'h01, 1'b0);
    queue_req(CMD_ADD, 32'h8000_0000, 8'h02, 1'b0);
    queue_req(CMD_ADD, 32'hFFFF_FFFF, 8'h03, 1'b0);
    // fill the list with timers that all expire on the next tick
    for (int i = 0; i < SLOTS; i++) begin
      queue_req(CMD_ADD, 32'd1, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 1'b0);
    end
    queue_req(CMD_ADD, 32'd5, 8'h55, 1'b0);
    // bad wait takes precedence over full
    queue_req(CMD_ADD, 32'h0000_0000, 8'hAA, 1'b0);
    queue_req(CMD_TICK, 32'($urandom), 8'($urandom), 1'b0);
    // deferred clear, repeated, survives a clear now and replaces the tick
    queue_req(CMD_CLR_NEXT, 32'($urandom), 8'($urandom), 1'b0);
    queue_req(CMD_ADD, 32'h7FFF_FFFF, 8'hFF, 1'b0);
    queue_req(CMD_CLR_NOW, 32'($urandom), 8'($urandom), 1'b0);
    queue_req(CMD_CLR_NEXT, 32'($urandom), 8'($urandom), 1'b0);
    queue_req(CMD_ADD, 32'd1, 8'h10, 1'b0);
    queue_req(CMD_TICK, 32'($urandom), 8'($urandom), 1'b0);
    queue_req(CMD_TICK, 32'($urandom), 8'($urandom), 1'b0);

    // random part: mostly adds and ticks, with fill-and-fire bursts
    paused = 1'b0;
    n_rand = 0;
    while (n_rand < 280) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_req(CMD_CLR_NOW, 32'($urandom), 8'($urandom), 1'b0);
        for (int i = 0; i < SLOTS; i++) begin
          queue_req(CMD_ADD, 32'($urandom_range(1, 2)), 8'($urandom), 1'b0);
        end
        queue_req(CMD_ADD, 32'($urandom_range(1, 9)), 8'($urandom), 1'b0);
        queue_req(CMD_TICK, 32'($urandom), 8'($urandom), 1'b0);
        queue_req(CMD_TICK, 32'($urandom), 8'($urandom), 1'b0);
        n_rand += SLOTS + 4;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 46) begin
          c = CMD_ADD;
        end else if (r < 86) begin
          c = CMD_TICK;
        end else if (r < 93) begin
          c = CMD_CLR_NOW;
        end else begin
          c = CMD_CLR_NEXT;
        end
        r = $urandom_range(0, 99);
        if (c != CMD_ADD || r >= 85) begin
          w = $urandom;
        end else if (r < 70) begin
          w = $urandom_range(1, 6);
        end else begin
          w = {1'b0, 31'($urandom)};
        end
        // hold off once mid-run until the block has gone quiet
        queue_req(c, w, 8'($urandom), (n_rand >= 150) && !paused);
        if (n_rand >= 150) paused = 1'b1;
        n_rand++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (timer_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: %0d ticks, %0d adds (%0d rejected)",
             n_taken, n_ticks, n_adds, n_rejects);
    $display("checked %0d results, %0d expirations, up to %0d from one tick",
             n_results, n_fired, max_burst);
    if (n_errors == 0) begin
      $display("tb_frame_tick_callback_timer_list_top: clean");
    end else begin
      $display("tb_frame_tick_callback_timer_list_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("run did not finish in time");
    $display("tb_frame_tick_callback_timer_list_top: errors");
    $finish;
  end

endmodule
`default_nettype wire
